### hw/rtl/dcf_pkg.sv
// Shared types and constants for the double to custom float converter.
package dcf_pkg;

    localparam int unsigned DBL_BIAS  = 1023;
    localparam int unsigned DBL_FRAC  = 52;
    localparam int unsigned DBL_SUBB  = 1074;
    localparam logic [10:0] EXP_ONES  = 11'h7FF;

    // Register index codes on the configuration port
    localparam logic REG_TOTAL_WIDTH    = 1'b0;
    localparam logic REG_EXPONENT_WIDTH = 1'b1;

    // Format values derived from the configuration registers
    typedef struct packed {
        logic        bad;
        logic [5:0]  sgn_pos;
        logic [5:0]  fb;
        logic [63:0] ones;
        logic [63:0] bias;
    } cfg_t;

    // Decode stage result
    typedef struct packed {
        logic               sign;
        logic               zero;
        logic               special;
        logic               nan;
        logic               sub;
        logic [5:0]         p;
        logic [51:0]        frac;
        logic signed [11:0] unb;
    } s1_t;

    // Align stage result
    typedef struct packed {
        logic               sign;
        logic               zero;
        logic               special;
        logic               nan;
        logic               ovf;
        logic               tiny;
        logic [63:0]        t;
        logic signed [63:0] s;
        logic [51:0]        frac;
    } s2_t;

endpackage

### hw/rtl/dcf_decode.sv
// First stage: split the double, classify it and find the top bit of a subnormal.
module dcf_decode (
    input  logic          aclk,
    input  logic          en,
    input  logic [63:0]   double_bits,
    output dcf_pkg::s1_t  q
);
    import dcf_pkg::*;

    logic [10:0] efield;
    logic [51:0] frac;
    logic [5:0]  p;
    s1_t         d;
    s1_t         q_reg;

    assign efield = double_bits[62:52];
    assign frac   = double_bits[51:0];

    // Find the highest set fraction bit
    always_comb begin
        p = 6'd0;
        for (int i = 0; i < 52; i++) begin
            if (frac[i]) begin
                p = 6'(i);
            end
        end
    end

    // Classify and get the unbiased exponent
    always_comb begin
        d.sign    = double_bits[63];
        d.zero    = (efield == 11'd0) && (frac == 52'd0);
        d.special = (efield == EXP_ONES);
        d.nan     = (frac != 52'd0);
        d.sub     = (efield == 11'd0) && (frac != 52'd0);
        d.p       = p;
        d.frac    = frac;
        if (d.sub) begin
            d.unb = $signed({6'd0, p}) - 12'(DBL_SUBB);
        end else begin
            d.unb = $signed({1'b0, efield}) - 12'(DBL_BIAS);
        end
    end

    // Hold on stall, load on advance
    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

### hw/rtl/dcf_align.sv
// Second stage: normalize subnormals, rebias and classify the target exponent.
module dcf_align (
    input  logic          aclk,
    input  logic          en,
    input  dcf_pkg::cfg_t cfg,
    input  dcf_pkg::s1_t  d,
    output dcf_pkg::s2_t  q
);
    import dcf_pkg::*;

    logic [5:0]  shamt;
    logic [63:0] unb_x;
    s2_t         n;
    s2_t         q_reg;

    assign shamt = 6'(DBL_FRAC) - d.p;
    assign unb_x = {{52{d.unb[11]}}, d.unb};

    always_comb begin
        n.sign    = d.sign;
        n.zero    = d.zero;
        n.special = d.special;
        n.nan     = d.nan;
        n.frac    = d.sub ? (d.frac << shamt) : d.frac;
        n.t       = unb_x + cfg.bias;
        n.s       = $signed(unb_x + cfg.bias + {58'd0, cfg.fb} - 64'd53);
        n.ovf     = $signed(n.t) >= $signed(cfg.ones);
        n.tiny    = $signed(n.t) <= 64'sd0;
    end

    // Hold on stall, load on advance
    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= n;
        end
    end

    assign q = q_reg;

endmodule

### hw/rtl/dcf_pack.sv
// Third stage: build the target bit pattern and register the result.
module dcf_pack (
    input  logic          aclk,
    input  logic          en,
    input  dcf_pkg::cfg_t cfg,
    input  dcf_pkg::s2_t  d,
    output logic [63:0]   float_bits,
    output logic          config_invalid
);
    import dcf_pkg::*;

    logic [63:0] sgn;
    logic [63:0] inf;
    logic [63:0] m;
    logic [63:0] ns;
    logic [63:0] fsub;
    logic [63:0] fnorm;
    logic [63:0] res;
    logic [63:0] float_bits_reg;
    logic        invalid_reg;

    assign sgn = {63'd0, d.sign} << cfg.sgn_pos;
    assign inf = sgn | (cfg.ones << cfg.fb);
    assign m   = {11'd0, 1'b1, d.frac};
    assign ns  = 64'd0 - d.s;

    // Subnormal fraction: one truncating shift
    always_comb begin
        if (d.s >= 64'sd0) begin
            fsub = m << d.s[5:0];
        end else if (ns[63:6] != 58'd0) begin
            fsub = 64'd0;
        end else begin
            fsub = m >> ns[5:0];
        end
    end

    // Normal fraction: drop or pad low bits
    always_comb begin
        if (cfg.fb < 6'(DBL_FRAC)) begin
            fnorm = {12'd0, d.frac} >> (6'(DBL_FRAC) - cfg.fb);
        end else begin
            fnorm = {12'd0, d.frac} << (cfg.fb - 6'(DBL_FRAC));
        end
    end

    // Select the result by class
    always_comb begin
        if (cfg.bad || d.zero) begin
            res = 64'd0;
        end else if (d.special) begin
            res = inf | {63'd0, d.nan};
        end else if (d.ovf) begin
            res = inf;
        end else if (d.tiny) begin
            res = sgn | fsub;
        end else begin
            res = sgn | (d.t << cfg.fb) | fnorm;
        end
    end

    // Hold on stall, load on advance
    always_ff @(posedge aclk) begin
        if (en) begin
            float_bits_reg <= res;
            invalid_reg    <= cfg.bad;
        end
    end

    assign float_bits     = float_bits_reg;
    assign config_invalid = invalid_reg;

endmodule

### hw/rtl/double_to_custom_float_core.sv
// Top level of the double to custom float converter: config port and pipeline control.
//
// Usage:
//   s_valid/s_ready/s_double_bits carry one binary64 pattern per item.
//   m_valid/m_ready/m_float_bits/m_config_invalid return one result per item,
//   right-aligned in the configured format, or zero with config_invalid set
//   when the width pair is invalid.
//   The APB-style port writes total_width at address 0 and exponent_width at
//   address 4; write them only while no item is in flight.
// Pipeline: three register stages (decode, align, pack); an accepted item is
//   registered in decode, align and pack in turn, and m_valid rises once pack holds it.
// Throughput: one item per cycle while m_ready stays high; each stage advances
//   when the stage after it is empty or moving, so bubbles are squeezed out.
// Stall: when m_ready is low the last stage holds, earlier stages keep filling
//   until all three are full, then s_ready drops.
// Reset: pipeline valids clear, total_width returns to 32 and exponent_width
//   to 8.
module double_to_custom_float_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_double_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_float_bits,
    output logic        m_config_invalid
);
    import dcf_pkg::*;

    logic [6:0] tw_reg;
    logic [5:0] ew_reg;
    logic       v1_reg;
    logic       v2_reg;
    logic       v3_reg;
    logic       adv1;
    logic       adv2;
    logic       adv3;
    logic [5:0] ew_m1;
    cfg_t       cfg;
    s1_t        s1;
    s2_t        s2;

    // Configuration registers
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tw_reg <= 7'd32;
            ew_reg <= 6'd8;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_TOTAL_WIDTH) begin
                tw_reg <= pwdata[6:0];
            end else begin
                ew_reg <= pwdata[5:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_EXPONENT_WIDTH) ? {26'd0, ew_reg} : {25'd0, tw_reg};

    // Derive format values
    assign ew_m1       = ew_reg - 6'd1;
    assign cfg.bad     = (tw_reg < 7'd3) || (tw_reg > 7'd64) || (ew_reg == 6'd0)
                         || ({1'b0, ew_reg} > (tw_reg - 7'd2));
    assign cfg.sgn_pos = 6'(tw_reg - 7'd1);
    assign cfg.fb      = 6'(tw_reg - 7'd1 - {1'b0, ew_reg});
    assign cfg.ones    = (64'd1 << ew_reg) - 64'd1;
    assign cfg.bias    = (64'd1 << ew_m1) - 64'd1;

    // Advance each stage when the next is empty or moving
    assign adv3    = !v3_reg || m_ready;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= s_valid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
            if (adv3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    dcf_decode u_decode (
        .aclk        (aclk),
        .en          (adv1),
        .double_bits (s_double_bits),
        .q           (s1)
    );

    dcf_align u_align (
        .aclk (aclk),
        .en   (adv2),
        .cfg  (cfg),
        .d    (s1),
        .q    (s2)
    );

    dcf_pack u_pack (
        .aclk           (aclk),
        .en             (adv3),
        .cfg            (cfg),
        .d              (s2),
        .float_bits     (m_float_bits),
        .config_invalid (m_config_invalid)
    );

    assign m_valid = v3_reg;

`ifndef ASSERT_OFF
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_config_invalid |-> m_float_bits == 64'd0)
        else $error("invalid config result not zero");

    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> v1_reg && v2_reg && v3_reg)
        else $error("input stalled with room in pipeline");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg && !m_ready |=> v3_reg)
        else $error("output item dropped while stalled");
`endif

endmodule

### dv/dcf_checker.sv
// Checker for the double to custom float converter: predicts each item and compares results.
`timescale 1ns / 100ps
module dcf_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [63:0] s_double_bits,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [63:0] m_float_bits,
    input  logic        m_config_invalid,
    output int          pending,
    output int          fails
);
    import dcf_pkg::*;

    typedef struct {
        logic [63:0] float_bits;
        logic        config_invalid;
    } conv_result_t;

    logic [6:0]   tw_reg;
    logic [5:0]   ew_reg;
    conv_result_t expected_q[$];
    int           fail_cnt;

    // Re-encode one binary64 pattern in the given format, truncating toward zero
    function automatic logic [63:0] to_custom_float(logic [63:0] x, int tw, int ew);
        int          fb;
        int          p;
        logic [10:0] efield;
        logic [51:0] frac;
        logic [63:0] ones;
        logic [63:0] sgn;
        logic [63:0] m;
        longint      bias;
        longint      unb;
        longint      t;
        longint      s;
        fb     = tw - 1 - ew;
        efield = x[62:52];
        frac   = x[51:0];
        ones   = (64'd1 << ew) - 64'd1;
        sgn    = {63'd0, x[63]} << (tw - 1);
        bias   = longint'((64'd1 << (ew - 1)) - 64'd1);
        if (efield == 11'd0 && frac == 52'd0) return 64'd0;
        if (efield == EXP_ONES) return sgn | (ones << fb) | {63'd0, frac != 52'd0};
        if (efield == 11'd0) begin
            p = 0;
            for (int i = 0; i < 52; i++) if (frac[i]) p = i;
            unb  = longint'(p) - 1074;
            frac = frac << (52 - p);
        end else begin
            unb = longint'(efield) - 1023;
        end
        t = unb + bias;
        if (t >= longint'(ones)) return sgn | (ones << fb);
        if (t <= 0) begin
            m = {12'd1, frac};
            s = (t - 1) + fb - 52;
            if (s >= 0) return sgn | (m << s);
            if (-s >= 64) return sgn;
            return sgn | (m >> (-s));
        end
        if (fb < 52) return sgn | (64'(t) << fb) | ({12'd0, frac} >> (52 - fb));
        return sgn | (64'(t) << fb) | ({12'd0, frac} << (fb - 52));
    endfunction

    function automatic conv_result_t predict_conv(logic [63:0] x, int tw, int ew);
        conv_result_t r;
        if (tw < 3 || tw > 64 || ew < 1 || ew > tw - 2) begin
            r.float_bits     = 64'd0;
            r.config_invalid = 1'b1;
        end else begin
            r.float_bits     = to_custom_float(x, tw, ew);
            r.config_invalid = 1'b0;
        end
        return r;
    endfunction

    // Track registers, queue predictions, compare results
    always @(posedge aclk) begin
        conv_result_t exp_r;
        if (!aresetn) begin
            tw_reg = 7'd32;
            ew_reg = 6'd8;
            expected_q.delete();
            fail_cnt = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result item with no expectation: float_bits %h", m_float_bits);
                    fail_cnt++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (m_float_bits !== exp_r.float_bits) begin
                        $error("float_bits expected %h actual %h",
                               exp_r.float_bits, m_float_bits);
                        fail_cnt++;
                    end
                    if (m_config_invalid !== exp_r.config_invalid) begin
                        $error("config_invalid expected %b actual %b",
                               exp_r.config_invalid, m_config_invalid);
                        fail_cnt++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_q.push_back(predict_conv(s_double_bits, tw_reg, ew_reg));
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_TOTAL_WIDTH) tw_reg = pwdata[6:0];
                else                             ew_reg = pwdata[5:0];
            end
        end
        pending <= expected_q.size();
        fails   <= fail_cnt;
    end
endmodule

### dv/tb.sv
// Testbench top for the double to custom float converter: stimulus, config writes and verdict.
`timescale 1ns / 100ps
module tb;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_double_bits = 64'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_float_bits;
    logic        m_config_invalid;
    int          pending;
    int          fails;
    int          tx_idle = 0;
    int          rx_idle = 0;
    int          cur_tw = 32;
    int          cur_ew = 8;
    int          n_items = 0;
    int          n_cfg = 0;

    always #1 aclk = ~aclk;

    double_to_custom_float_core uut (.*);

    dcf_checker chk (.*);

    // Stall the result channel at random
    always @(posedge aclk) m_ready <= ($urandom_range(0, 99) >= rx_idle);

    initial begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

    task automatic send_item(logic [63:0] x);
        while ($urandom_range(0, 99) < tx_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_double_bits <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_items++;
    endtask

    // Drain the pipeline, then write both width registers
    task automatic set_widths(int tw, int ew);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        for (int r = 0; r < 2; r++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= (r == 0) ? 3'd0 : 3'd4;
            pwdata  <= (r == 0) ? 32'(tw) : 32'(ew);
            @(posedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        cur_tw = tw;
        cur_ew = ew;
        n_cfg++;
    endtask

    // Half the values near the format's exponent range, the rest specials, subnormals and raw noise
    function automatic logic [63:0] rand_double();
        logic [63:0] x;
        longint      b;
        longint      e;
        x = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: ;
            1: x[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
            2: x[62:52] = 11'h000;
            default: begin
                b = (cur_ew >= 11 || cur_ew < 1) ? 1100 : ((longint'(1) << (cur_ew - 1)) - 1);
                if ($urandom_range(0, 1)) e = 1023 - b - 64 + $urandom_range(0, 70);
                else                      e = 1023 + b - 3 + $urandom_range(0, 6);
                if (e < 1) e = $urandom_range(1, 2046);
                if (e > 2046) e = $urandom_range(1, 2046);
                x[62:52] = 11'(e);
            end
        endcase
        return x;
    endfunction

    logic [63:0] directed[] = '{
        64'h0000000000000000, 64'h8000000000000000, 64'h7FF0000000000000,
        64'hFFF0000000000000, 64'h7FF8000000000000, 64'hFFF0000000000001,
        64'h0000000000000001, 64'h800FFFFFFFFFFFFF, 64'h0010000000000000,
        64'h7FEFFFFFFFFFFFFF, 64'h3FF0000000000000, 64'hBFF0000000000000,
        64'h47EFFFFFE0000000, 64'h47F0000000000000, 64'h3810000000000000,
        64'h380FFFFFFFFFFFFF, 64'h36A0000000000000, 64'h3690000000000000,
        64'hFFFFFFFFFFFFFFFF, 64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA
    };

    int cfg_tw[18] = '{64, 3, 64, 2, 127, 32, 16, 64, 10, 0, 40, 24, 0, 0, 0, 0, 0, 0};
    int cfg_ew[18] = '{11, 1, 62, 1, 8, 0, 5, 1, 8, 0, 63, 31, 0, 0, 0, 0, 0, 0};

    initial begin
        int tw;
        int ew;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Directed corners at the reset format, then at double width
        foreach (directed[i]) send_item(directed[i]);
        set_widths(64, 11);
        foreach (directed[i]) send_item(directed[i]);
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle = (ph == 0) ? 33 : (ph == 1) ? 62 : 0;
            rx_idle = (ph == 0) ? 62 : (ph == 1) ? 33 : 0;
            for (int k = 0; k < 6; k++) begin
                tw = cfg_tw[ph * 6 + k];
                ew = cfg_ew[ph * 6 + k];
                if (tw == 0 && ew == 0) begin
                    tw = $urandom_range(3, 64);
                    ew = $urandom_range(1, tw - 2);
                end
                set_widths(tw, ew);
                repeat (28) send_item(rand_double());
            end
        end
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        $display("Converted %0d items over %0d width settings, valid and invalid,",
                 n_items, n_cfg);
        $display("with random stalls on both channels and a stall-free stretch.");
        if (fails == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

### sim.f
hw/rtl/dcf_pkg.sv
hw/rtl/dcf_decode.sv
hw/rtl/dcf_align.sv
hw/rtl/dcf_pack.sv
hw/rtl/double_to_custom_float_core.sv
dv/dcf_checker.sv
dv/tb.sv
